// ----- rtl/iprm_pkg.sv -----
package iprm_pkg;

    localparam logic [7:0]  TYPE_ECHO_REPLY    = 8'd0;
    localparam logic [7:0]  TYPE_TIME_EXCEEDED = 8'd11;
    localparam logic [6:0]  ICMP_HDR_BYTES     = 7'd8;
    localparam logic [10:0] OFFSET_MAX         = 11'd2047;
    localparam logic [15:0] MAX_PACKET_BYTES   = 16'd1024;

    localparam logic REG_EXPECTED_IDENT    = 1'b0;
    localparam logic REG_EXPECTED_SEQUENCE = 1'b1;

    typedef enum logic [1:0] {
        STATUS_ACCEPTED  = 2'd0,
        STATUS_TOO_SHORT = 2'd1,
        STATUS_OTHER     = 2'd2,
        STATUS_MISMATCH  = 2'd3
    } status_t;

    // Byte tagged with its role in the packet
    typedef struct packed {
        logic [7:0] data;
        logic       last;
        logic       src_en;
        logic [1:0] src_idx;
        logic       type_en;
        logic       idseq_en;
        logic [1:0] idseq_sel;
    } front_word_t;

    typedef struct packed {
        status_t     status;
        logic        reply_kind;
        logic [31:0] source_addr;
    } result_t;

endpackage

// ----- rtl/iprm_fifo.sv -----
module iprm_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  logic [WIDTH-1:0] wdata,
    output logic             full,
    input  logic             pop,
    output logic [WIDTH-1:0] rdata,
    output logic             empty
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [PW-1:0] LAST_PTR = PW'(DEPTH - 1);
    localparam logic [CW-1:0] FULL_COUNT = CW'(DEPTH);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [PW-1:0]    wr_ptr_reg;
    logic [PW-1:0]    rd_ptr_reg;
    logic [CW-1:0]    count_reg;
    logic             do_push;
    logic             do_pop;

    assign full    = (count_reg == FULL_COUNT);
    assign empty   = (count_reg == '0);
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign rdata   = mem_reg[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wr_ptr_reg] <= wdata;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (do_pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + 1'b1;
            end
            if (do_push && !do_pop)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (do_pop && !do_push)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

endmodule

// ----- rtl/iprm_front.sv -----
module iprm_front (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      accept,
    input  logic [7:0]                packet_byte,
    input  logic                      is_last,
    output iprm_pkg::front_word_t     word
);

    logic [10:0] offset_reg;
    logic [5:0]  ohb_reg;
    logic        type_seen_reg;
    logic        is_te_reg;
    logic [5:0]  ihb_reg;
    logic        inner_seen_reg;

    logic        in_rng;
    logic [5:0]  ihl_bytes;
    logic [5:0]  ohb_eff;
    logic        type_hit;
    logic        proceed;
    logic [10:0] rel_outer;
    logic        outer_take;
    logic [6:0]  inner_ip;
    logic        inner_hit;
    logic [7:0]  base;
    logic [10:0] rel_inner;
    logic        inner_take;

    assign in_rng    = ({5'b0, offset_reg} < iprm_pkg::MAX_PACKET_BYTES);
    assign ihl_bytes = {packet_byte[3:0], 2'b00};
    assign ohb_eff   = (offset_reg == '0) ? ihl_bytes : ohb_reg;
    assign type_hit  = in_rng && (offset_reg == {5'b0, ohb_eff});
    assign proceed   = in_rng && type_seen_reg && (offset_reg > {5'b0, ohb_reg});

    // Outer ICMP header: id and sequence at bytes 4..7
    assign rel_outer  = offset_reg - {5'b0, ohb_reg};
    assign outer_take = proceed && !is_te_reg && (rel_outer[10:2] == 9'd1);

    // Time exceeded: skip the quoted IP header, then the inner ICMP bytes 4..7
    assign inner_ip   = {1'b0, ohb_reg} + iprm_pkg::ICMP_HDR_BYTES;
    assign inner_hit  = proceed && is_te_reg && (offset_reg == {4'b0, inner_ip});
    assign base       = {1'b0, inner_ip} + {2'b0, ihb_reg};
    assign rel_inner  = offset_reg - {3'b0, base};
    assign inner_take = proceed && is_te_reg && inner_seen_reg && (rel_inner[10:2] == 9'd1);

    always_comb
    begin
        word.data      = packet_byte;
        word.last      = is_last;
        word.src_en    = in_rng && (offset_reg[10:2] == 9'd3);
        word.src_idx   = offset_reg[1:0];
        word.type_en   = type_hit;
        word.idseq_en  = outer_take || inner_take;
        word.idseq_sel = outer_take ? rel_outer[1:0] : rel_inner[1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            offset_reg     <= '0;
            ohb_reg        <= '0;
            type_seen_reg  <= 1'b0;
            is_te_reg      <= 1'b0;
            ihb_reg        <= '0;
            inner_seen_reg <= 1'b0;
        end
        else if (accept)
        begin
            if (is_last)
            begin
                offset_reg     <= '0;
                ohb_reg        <= '0;
                type_seen_reg  <= 1'b0;
                is_te_reg      <= 1'b0;
                ihb_reg        <= '0;
                inner_seen_reg <= 1'b0;
            end
            else
            begin
                if (offset_reg < iprm_pkg::OFFSET_MAX)
                begin
                    offset_reg <= offset_reg + 1'b1;
                end
                if (in_rng && (offset_reg == '0))
                begin
                    ohb_reg <= ihl_bytes;
                end
                if (type_hit)
                begin
                    type_seen_reg <= 1'b1;
                    is_te_reg     <= (packet_byte == iprm_pkg::TYPE_TIME_EXCEEDED);
                end
                if (inner_hit)
                begin
                    ihb_reg        <= ihl_bytes;
                    inner_seen_reg <= 1'b1;
                end
            end
        end
    end

endmodule

// ----- rtl/iprm_back.sv -----
module iprm_back (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_write,
    input  logic                  cfg_index,
    input  logic [15:0]           cfg_data,
    input  iprm_pkg::front_word_t word,
    input  logic                  word_valid,
    input  logic                  out_full,
    output logic                  take,
    output logic                  res_valid,
    output iprm_pkg::result_t     res
);

    logic [15:0] exp_ident_reg;
    logic [15:0] exp_seq_reg;
    logic [31:0] src_reg;
    logic [31:0] src_next;
    logic [15:0] ident_reg;
    logic [15:0] ident_next;
    logic [15:0] seq_reg;
    logic [15:0] seq_next;
    logic [7:0]  type_reg;
    logic [7:0]  type_next;
    logic        done_reg;
    logic        done_next;

    // Hold a last word until the result queue has room
    assign take      = word_valid && (!word.last || !out_full);
    assign res_valid = take && word.last;

    always_comb
    begin
        src_next   = src_reg;
        ident_next = ident_reg;
        seq_next   = seq_reg;
        type_next  = type_reg;
        done_next  = done_reg;
        if (word.src_en)
        begin
            case (word.src_idx)
                2'd0:    src_next[31:24] = word.data;
                2'd1:    src_next[23:16] = word.data;
                2'd2:    src_next[15:8]  = word.data;
                default: src_next[7:0]   = word.data;
            endcase
        end
        if (word.type_en)
        begin
            type_next = word.data;
        end
        if (word.idseq_en)
        begin
            case (word.idseq_sel)
                2'd0:    ident_next[15:8] = word.data;
                2'd1:    ident_next[7:0]  = word.data;
                2'd2:    seq_next[15:8]   = word.data;
                default:
                begin
                    seq_next[7:0] = word.data;
                    done_next     = 1'b1;
                end
            endcase
        end
    end

    always_comb
    begin
        res.source_addr = src_next;
        res.reply_kind  = 1'b0;
        if (!done_next)
        begin
            res.status = iprm_pkg::STATUS_TOO_SHORT;
        end
        else if ((type_next == iprm_pkg::TYPE_ECHO_REPLY) ||
                 (type_next == iprm_pkg::TYPE_TIME_EXCEEDED))
        begin
            if ((ident_next == exp_ident_reg) && (seq_next == exp_seq_reg))
            begin
                res.status     = iprm_pkg::STATUS_ACCEPTED;
                res.reply_kind = (type_next == iprm_pkg::TYPE_TIME_EXCEEDED);
            end
            else
            begin
                res.status = iprm_pkg::STATUS_MISMATCH;
            end
        end
        else
        begin
            res.status = iprm_pkg::STATUS_OTHER;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            exp_ident_reg <= '0;
            exp_seq_reg   <= '0;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                iprm_pkg::REG_EXPECTED_IDENT:    exp_ident_reg <= cfg_data;
                iprm_pkg::REG_EXPECTED_SEQUENCE: exp_seq_reg   <= cfg_data;
                default:                         exp_ident_reg <= exp_ident_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            src_reg   <= '0;
            ident_reg <= '0;
            seq_reg   <= '0;
            type_reg  <= '0;
            done_reg  <= 1'b0;
        end
        else if (take)
        begin
            if (word.last)
            begin
                // drop the packet state once its result is out
                src_reg   <= '0;
                ident_reg <= '0;
                seq_reg   <= '0;
                type_reg  <= '0;
                done_reg  <= 1'b0;
            end
            else
            begin
                src_reg   <= src_next;
                ident_reg <= ident_next;
                seq_reg   <= seq_next;
                type_reg  <= type_next;
                done_reg  <= done_next;
            end
        end
    end

endmodule

// ----- rtl/icmp_probe_reply_matcher_top.sv -----
// Flow: the tagged word of a packet's last byte waits in the tagging queue; the back end
// then pushes the packet's result into the result queue, which reads straight through.
// Throughput: one byte per cycle while full is low.
// Input stalls only when the two-word tagging queue fills behind a full result queue.
// Reset (rst_n low, asynchronous): queues emptied, packet state cleared,
// expected identifier and sequence set to zero.
module icmp_probe_reply_matcher_top (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        push,
    output logic        full,
    input  logic [7:0]  packet_byte,
    input  logic        is_last,
    output logic        empty,
    input  logic        pop,
    output logic [1:0]  status,
    output logic        reply_kind,
    output logic [31:0] source_addr,
    input  logic        cfg_write,
    input  logic        cfg_index,
    input  logic [15:0] cfg_data
);

    localparam int WORD_W = $bits(iprm_pkg::front_word_t);
    localparam int RES_W  = $bits(iprm_pkg::result_t);

    iprm_pkg::front_word_t front_word;
    iprm_pkg::front_word_t back_word;
    iprm_pkg::result_t     back_res;
    iprm_pkg::result_t     out_res;
    logic [WORD_W-1:0]     mid_rdata;
    logic [RES_W-1:0]      out_rdata;
    logic                  accept;
    logic                  mid_empty;
    logic                  back_take;
    logic                  res_valid;
    logic                  out_full;

    assign accept = push && !full;

    iprm_front u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .accept      (accept),
        .packet_byte (packet_byte),
        .is_last     (is_last),
        .word        (front_word)
    );

    iprm_fifo #(
        .WIDTH (WORD_W),
        .DEPTH (2)
    ) u_mid_fifo (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (push),
        .wdata (front_word),
        .full  (full),
        .pop   (back_take),
        .rdata (mid_rdata),
        .empty (mid_empty)
    );

    assign back_word = iprm_pkg::front_word_t'(mid_rdata);

    iprm_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_write  (cfg_write),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .word       (back_word),
        .word_valid (!mid_empty),
        .out_full   (out_full),
        .take       (back_take),
        .res_valid  (res_valid),
        .res        (back_res)
    );

    iprm_fifo #(
        .WIDTH (RES_W),
        .DEPTH (2)
    ) u_out_fifo (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (res_valid),
        .wdata (back_res),
        .full  (out_full),
        .pop   (pop),
        .rdata (out_rdata),
        .empty (empty)
    );

    assign out_res     = iprm_pkg::result_t'(out_rdata);
    assign status      = out_res.status;
    assign reply_kind  = out_res.reply_kind;
    assign source_addr = out_res.source_addr;

    a_no_result_overflow: assert property (
        @(posedge clk) disable iff (!rst_n) res_valid |-> !out_full)
        else $error("result pushed into a full queue");

    a_take_has_word: assert property (
        @(posedge clk) disable iff (!rst_n) back_take |-> !mid_empty)
        else $error("back end took a word from an empty queue");

    a_kind_only_accepted: assert property (
        @(posedge clk) disable iff (!rst_n)
        (res_valid && back_res.reply_kind) |-> (back_res.status == iprm_pkg::STATUS_ACCEPTED))
        else $error("reply kind set on a rejected packet");

endmodule

// ----- test/tb_icmp_probe_reply_matcher_top.sv -----
`timescale 1ns / 1ps

module tb_icmp_probe_reply_matcher_top;

    typedef enum int {
        SHAPE_ECHO,
        SHAPE_TIME_EXCEEDED,
        SHAPE_OTHER_TYPE,
        SHAPE_NOISE
    } packet_shape_t;

    // Tracks the parser state per packet and holds the replies still owed by the block
    class reply_scoreboard;
        logic [15:0] want_ident    = '0;
        logic [15:0] want_sequence = '0;
        logic [10:0] offset        = '0;
        logic [5:0]  outer_len     = '0;
        logic [7:0]  icmp_type     = '0;
        logic [5:0]  inner_len     = '0;
        logic [31:0] source        = '0;
        logic [15:0] ident         = '0;
        logic [15:0] seq_no        = '0;
        logic [2:0]  present       = '0;
        iprm_pkg::result_t awaited[$];
        int          errors        = 0;

        function void set_register(logic idx, logic [15:0] value);
            if (idx == iprm_pkg::REG_EXPECTED_IDENT)
                want_ident = value;
            else
                want_sequence = value;
        endfunction

        function void clear_packet();
            offset    = '0;
            outer_len = '0;
            icmp_type = '0;
            inner_len = '0;
            source    = '0;
            ident     = '0;
            seq_no    = '0;
            present   = '0;
        endfunction

        function void take_id_seq(int rel, logic [7:0] b);
            case (rel)
                4: ident[15:8] = b;
                5: ident[7:0] = b;
                6: seq_no[15:8] = b;
                7:
                begin
                    seq_no[7:0] = b;
                    present[2] = 1'b1;
                end
                default: ;
            endcase
        endfunction

        function void capture(int off, logic [7:0] b);
            int inner_ip;
            int base;
            if (off == 0)
                outer_len = {b[3:0], 2'b00};
            if (off >= 12 && off <= 15)
                source[8 * (15 - off) +: 8] = b;
            if (off == outer_len)
            begin
                icmp_type = b;
                present[0] = 1'b1;
            end
            if (!present[0] || off <= outer_len)
                return;
            if (icmp_type != iprm_pkg::TYPE_TIME_EXCEEDED)
            begin
                if (off - outer_len < iprm_pkg::ICMP_HDR_BYTES)
                    take_id_seq(off - outer_len, b);
            end
            else
            begin
                // skip the quoted inner IP header behind the outer ICMP header
                inner_ip = outer_len + iprm_pkg::ICMP_HDR_BYTES;
                if (off == inner_ip)
                begin
                    inner_len = {b[3:0], 2'b00};
                    present[1] = 1'b1;
                end
                if (present[1])
                begin
                    base = inner_ip + inner_len;
                    if (off > base && off - base < iprm_pkg::ICMP_HDR_BYTES)
                        take_id_seq(off - base, b);
                end
            end
        endfunction

        function void note_byte(logic [7:0] b, logic last);
            int                off;
            iprm_pkg::result_t r;
            off = offset;
            if (off < iprm_pkg::MAX_PACKET_BYTES)
                capture(off, b);
            if (!last)
            begin
                if (off < iprm_pkg::OFFSET_MAX)
                    offset = offset + 11'd1;
                return;
            end
            r.source_addr = source;
            r.reply_kind  = 1'b0;
            if (!present[2])
                r.status = iprm_pkg::STATUS_TOO_SHORT;
            else if (icmp_type == iprm_pkg::TYPE_ECHO_REPLY ||
                     icmp_type == iprm_pkg::TYPE_TIME_EXCEEDED)
            begin
                if (ident == want_ident && seq_no == want_sequence)
                begin
                    r.status     = iprm_pkg::STATUS_ACCEPTED;
                    r.reply_kind = (icmp_type == iprm_pkg::TYPE_TIME_EXCEEDED);
                end
                else
                    r.status = iprm_pkg::STATUS_MISMATCH;
            end
            else
                r.status = iprm_pkg::STATUS_OTHER;
            awaited.push_back(r);
            clear_packet();
        endfunction

        function void check_reply(logic [1:0] st, logic kind, logic [31:0] src);
            iprm_pkg::result_t exp;
            if (awaited.size() == 0)
            begin
                $display("%0t: reply with none awaited: status %0d kind %0d source %08h",
                         $time, st, kind, src);
                errors++;
                return;
            end
            exp = awaited.pop_front();
            if (st !== exp.status)
            begin
                $display("%0t: status expected %0d actual %0d", $time, exp.status, st);
                errors++;
            end
            if (kind !== exp.reply_kind)
            begin
                $display("%0t: reply_kind expected %0d actual %0d",
                         $time, exp.reply_kind, kind);
                errors++;
            end
            if (src !== exp.source_addr)
            begin
                $display("%0t: source_addr expected %08h actual %08h",
                         $time, exp.source_addr, src);
                errors++;
            end
        endfunction
    endclass

    logic        clk         = 1'b0;
    logic        rst_n       = 1'b0;
    logic        push        = 1'b0;
    logic        full;
    logic [7:0]  packet_byte = '0;
    logic        is_last     = 1'b0;
    logic        empty;
    logic        pop         = 1'b0;
    logic [1:0]  status;
    logic        reply_kind;
    logic [31:0] source_addr;
    logic        cfg_write   = 1'b0;
    logic        cfg_index   = 1'b0;
    logic [15:0] cfg_data    = '0;

    reply_scoreboard sb = new;
    logic [7:0]      pkt[$];
    bit              tx_idle;
    int              rx_hold_cycles = 0;

    icmp_probe_reply_matcher_top uut (
        .clk         (clk),
        .rst_n       (rst_n),
        .push        (push),
        .full        (full),
        .packet_byte (packet_byte),
        .is_last     (is_last),
        .empty       (empty),
        .pop         (pop),
        .status      (status),
        .reply_kind  (reply_kind),
        .source_addr (source_addr),
        .cfg_write   (cfg_write),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data)
    );

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    // Entered just after a rising edge; returns at the edge that takes the word
    task automatic send_byte(input logic [7:0] b, input logic last);
        int gap;
        gap = tx_idle ? $urandom_range(0, 19) : 0;
        if (gap > 0)
        begin
            @(negedge clk);
            push <= 1'b0;
            repeat (gap - 1) @(negedge clk);
        end
        @(negedge clk);
        push        <= 1'b1;
        packet_byte <= b;
        is_last     <= last;
        do
            @(posedge clk);
        while (full);
        sb.note_byte(b, last);
    endtask

    task automatic send_packet();
        for (int i = 0; i < pkt.size(); i++)
            send_byte(pkt[i], i == pkt.size() - 1);
    endtask

    task automatic build_packet(input packet_shape_t shape, input int extra_lo,
                                input int extra_hi);
        int          ihl;
        int          iihl;
        int          ohb;
        int          base;
        int          len;
        logic [7:0]  t;
        logic [15:0] id;
        logic [15:0] sq;
        pkt.delete();
        if (shape == SHAPE_NOISE)
        begin
            len = $urandom_range(1, 40);
            repeat (len) pkt.push_back(8'($urandom));
            return;
        end
        ihl  = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 15) : 5;
        iihl = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 15) : 5;
        ohb  = ihl * 4;
        base = (shape == SHAPE_TIME_EXCEEDED) ? ohb + 8 + iihl * 4 : ohb;
        len  = base + 8 + $urandom_range(extra_lo, extra_hi);
        repeat (len) pkt.push_back(8'($urandom));
        pkt[0] = {4'($urandom), 4'(ihl)};
        if (shape == SHAPE_ECHO)
            t = iprm_pkg::TYPE_ECHO_REPLY;
        else if (shape == SHAPE_TIME_EXCEEDED)
            t = iprm_pkg::TYPE_TIME_EXCEEDED;
        else
        begin
            t = 8'($urandom_range(1, 255));
            if (t == iprm_pkg::TYPE_TIME_EXCEEDED)
                t = 8'd3;
        end
        pkt[ohb] = t;
        if (shape == SHAPE_TIME_EXCEEDED)
            pkt[ohb + 8] = {4'($urandom), 4'(iihl)};
        id = ($urandom_range(0, 4) == 0) ? 16'($urandom) : sb.want_ident;
        sq = ($urandom_range(0, 4) == 0) ? 16'($urandom) : sb.want_sequence;
        pkt[base + 4] = id[15:8];
        pkt[base + 5] = id[7:0];
        pkt[base + 6] = sq[15:8];
        pkt[base + 7] = sq[7:0];
        // cut some packets short, anywhere
        if ($urandom_range(0, 5) == 0)
        begin
            len = $urandom_range(1, len);
            while (pkt.size() > len)
                void'(pkt.pop_back());
        end
    endtask

    task automatic write_register(input logic idx, input logic [15:0] value);
        @(negedge clk);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(posedge clk);
        sb.set_register(idx, value);
    endtask

    task automatic set_match(input logic [15:0] ident, input logic [15:0] seq_no);
        write_register(iprm_pkg::REG_EXPECTED_IDENT, ident);
        write_register(iprm_pkg::REG_EXPECTED_SEQUENCE, seq_no);
        @(negedge clk);
        cfg_write <= 1'b0;
    endtask

    task automatic drain_replies();
        @(negedge clk);
        push <= 1'b0;
        while (sb.awaited.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    // Result side
    initial
    begin
        int  gap;
        bit  rx_idle;
        int  seen;
        seen    = 0;
        rx_idle = 1'b0;
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever
        begin
            if (seen % 10 == 0)
                rx_idle = $urandom_range(0, 1);
            gap = rx_idle ? $urandom_range(0, 19) : 0;
            if (rx_hold_cycles > 0)
            begin
                gap = rx_hold_cycles;
                rx_hold_cycles = 0;
            end
            if (gap > 0)
            begin
                @(negedge clk);
                pop <= 1'b0;
                repeat (gap - 1) @(negedge clk);
            end
            @(negedge clk);
            pop <= 1'b1;
            do
                @(posedge clk);
            while (empty);
            sb.check_reply(status, reply_kind, source_addr);
            seen++;
        end
    end

    initial
    begin
        logic [15:0] ident_set[5];
        logic [15:0] seq_set[5];
        int          phase_bytes;
        int          phase_packets;
        int          pick;
        packet_shape_t shape;

        repeat (5) @(negedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed part, with the registers at their reset values
        tx_idle = 1'b0;
        pkt = '{8'hFF};
        send_packet();
        // header length zero: the ICMP header overlaps the IP header
        pkt = '{8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00};
        send_packet();
        pkt = '{8'h20, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF};
        send_packet();
        pkt = '{8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h01, 8'h00, 8'h00};
        send_packet();
        drain_replies();

        ident_set = '{16'hFFFF, 16'($urandom), 16'h0000, 16'hFFFF, 16'($urandom)};
        seq_set   = '{16'hFFFF, 16'($urandom), 16'hFFFF, 16'h0000, 16'($urandom)};

        for (int p = 0; p < 5; p++)
        begin
            set_match(ident_set[p], seq_set[p]);
            if (p == 2)
            begin
                // stall the result side while short packets keep coming
                rx_hold_cycles = 500;
                tx_idle = 1'b0;
                repeat (80)
                begin
                    pkt = '{8'($urandom)};
                    send_packet();
                end
            end
            phase_bytes   = 0;
            phase_packets = 0;
            while (phase_bytes < 70 || phase_packets < 2)
            begin
                tx_idle = $urandom_range(0, 1);
                pick = $urandom_range(0, 19);
                if (pick < 7)
                    shape = SHAPE_ECHO;
                else if (pick < 14)
                    shape = SHAPE_TIME_EXCEEDED;
                else if (pick < 16)
                    shape = SHAPE_OTHER_TYPE;
                else
                    shape = SHAPE_NOISE;
                build_packet(shape, 0, 12);
                phase_bytes += pkt.size();
                phase_packets++;
                send_packet();
            end
            drain_replies();
        end

        repeat (10) @(posedge clk);
        if (sb.errors == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

    initial
    begin
        #9600000;
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
